### design/sis_pkg.sv
`default_nettype none

package sis_pkg;

    localparam int DEPTH    = 16;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_PUSH_FULL = 2'd1,
        ST_POP_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic apply;
        logic load_out;
    } t_dp_cmd;

endpackage

`default_nettype wire

### design/sis_in_if.sv
`default_nettype none

interface sis_in_if;
    logic                               valid;
    logic                               ready;
    logic                               command;
    logic signed [sis_pkg::VAL_W-1:0]   value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

`default_nettype wire

### design/sis_out_if.sv
`default_nettype none

interface sis_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [sis_pkg::VAL_W-1:0]   top_value;
    logic [sis_pkg::COUNT_W-1:0]        count;
    logic                               is_empty;
    logic [sis_pkg::STATUS_W-1:0]       status;

    modport source (output valid, output top_value, output count, output is_empty,
                    output status, input ready);
    modport sink   (input valid, input top_value, input count, input is_empty,
                    input status, output ready);
endinterface

`default_nettype wire

### design/sorted_insert_stack_core.sv
// Sorted insert stack: bounded store of signed 32-bit values kept in order so
// the smallest value is always on top.
// Input channel i_in: command (0 push value, 1 pop top) and value, one beat per
// operation. Output channel o_out: one beat per operation carrying the new top
// value (0 when empty), the count, an empty flag and a status (0 ok, 1 push
// refused because full, 2 pop refused because empty).
// A push compares the value against every cell in parallel and shifts the
// cells above the insert point up by one in the same cycle.
// The apply step writes the cells, count and status registers; the result
// load then copies the result from them into the output register. The two-state
// controller (apply, then result load) keeps i_in.ready high only while idle.
// The result sits in an output register; a new input beat is taken while it
// waits. If o_out.ready stays low, the following operation is applied but its
// result waits in the datapath registers until the output register frees up.
// Reset (synchronous, active low) empties the stack and drops any pending
// result beat; cell contents are not cleared.
`default_nettype none

module sorted_insert_stack_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sis_in_if.sink      i_in,
    sis_out_if.source   o_out
);
    import sis_pkg::*;

    t_dp_cmd cmd;

    sis_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    sis_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_command   (i_in.command),
        .i_value     (i_in.value),
        .o_top_value (o_out.top_value),
        .o_count     (o_out.count),
        .o_is_empty  (o_out.is_empty),
        .o_status    (o_out.status)
    );

endmodule

`default_nettype wire

### design/sis_ctrl.sv
`default_nettype none

module sis_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    output sis_pkg::t_dp_cmd     o_cmd
);
    import sis_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;
    logic   out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd.apply    = 1'b0;
        o_cmd.load_out = 1'b0;
        out_free       = !r_out_vld || i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.apply = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.load_out = out_free;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (o_cmd.load_out) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

`default_nettype wire

### design/sis_dp.sv
`default_nettype none

module sis_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire sis_pkg::t_dp_cmd               i_cmd,
    input  wire logic                           i_command,
    input  wire logic signed [sis_pkg::VAL_W-1:0] i_value,
    output logic signed [sis_pkg::VAL_W-1:0]    o_top_value,
    output logic [sis_pkg::COUNT_W-1:0]         o_count,
    output logic                                o_is_empty,
    output logic [sis_pkg::STATUS_W-1:0]        o_status
);
    import sis_pkg::*;

    // cell 0 is the bottom, cell r_count-1 the top
    logic signed [VAL_W-1:0] r_cell [DEPTH];
    logic signed [VAL_W-1:0] n_cell [DEPTH];
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    t_status                 r_status;
    t_status                 n_status;
    logic [DEPTH-1:0]        shift_up;
    logic                    full;
    logic                    empty;
    logic                    do_push;
    logic [CNT_W-1:0]        top_sel;
    logic signed [VAL_W-1:0] top_val;
    logic [COUNT_W+CNT_W-1:0] count_ext;

    assign full    = (r_count == CNT_W'(DEPTH));
    assign empty   = (r_count == '0);
    assign do_push = i_cmd.apply && (i_command == CMD_PUSH) && !full;

    // cell i moves up (or takes the new value) when it holds a value smaller than
    // the new one, or is the first free cell
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (CNT_W'(i) < r_count) begin
                shift_up[i] = (r_cell[i] < i_value);
            end else begin
                shift_up[i] = (CNT_W'(i) == r_count);
            end
        end
        for (int i = 0; i < DEPTH; i++) begin
            n_cell[i] = r_cell[i];
            if (do_push && shift_up[i]) begin
                if (i > 0 && shift_up[(i > 0) ? i - 1 : 0]) begin
                    n_cell[i] = r_cell[(i > 0) ? i - 1 : 0];
                end else begin
                    n_cell[i] = i_value;
                end
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = r_status;
        if (i_cmd.apply) begin
            n_status = ST_OK;
            if (i_command == CMD_PUSH) begin
                if (full) begin
                    n_status = ST_PUSH_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end else begin
                if (empty) begin
                    n_status = ST_POP_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell   <= n_cell;
        r_status <= n_status;
    end

    assign top_sel   = r_count - CNT_W'(1);
    assign top_val   = empty ? '0 : r_cell[top_sel[IDX_W-1:0]];
    assign count_ext = {{COUNT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_top_value <= top_val;
            o_count     <= count_ext[COUNT_W-1:0];
            o_is_empty  <= empty;
            o_status    <= r_status;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push |=> (r_count == $past(r_count) + CNT_W'(1)) && (r_status == ST_OK))
        else $error("push did not grow the stack");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && i_command == CMD_POP && empty)
        |=> (r_status == ST_POP_EMPTY) && (r_count == '0))
        else $error("refused pop changed state");

    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && i_command == CMD_PUSH && full)
        |=> (r_status == ST_PUSH_FULL) && $stable(r_count))
        else $error("refused push changed state");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.apply && i_cmd.load_out))
        else $error("apply and result load in one cycle");
`endif

endmodule

`default_nettype wire
